// ----- hw/rtl/tensor_permute_address_generator_top_macros.svh -----
// Assertion macros for the tensor permute address generator checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef TENSOR_PERMUTE_ADDRESS_GENERATOR_TOP_MACROS_SVH
`define TENSOR_PERMUTE_ADDRESS_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define TPAG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPAG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tpag_pkg.sv -----
// Shared types, constants and helper functions for the tensor permute
// address generator. No dependencies.
`default_nettype none

package tpag_pkg;

    localparam int MAX_RANK        = 5;
    localparam int DIM_BITS        = 16;
    localparam int ADDR_BITS       = 32;
    localparam int VALUE_BITS      = 32;
    localparam int RANK_BITS       = 3;
    localparam int PERM_FIELD_BITS = 3;
    localparam int PERM_BITS       = PERM_FIELD_BITS * MAX_RANK;
    localparam int IDX_BITS        = PERM_FIELD_BITS;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_RANK_COUNT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_SIZE_0 = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PERM_MAP   = 3'd6;

    typedef logic [DIM_BITS-1:0]  dim_t;
    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [IDX_BITS-1:0]  idx_t;
    typedef logic [RANK_BITS-1:0] rank_t;
    typedef logic [PERM_BITS-1:0] perm_t;

    // builder -> cell write bus
    typedef struct packed {
        logic  clear;
        logic  stride_we;
        logic  step_we;
        idx_t  sel;
        addr_t data;
    } cell_wr_t;

    function automatic rank_t ranks_used(input rank_t r);
        rank_t res;
        res = r;
        if (r == '0)
            res = RANK_BITS'(1);
        else if (r > RANK_BITS'(MAX_RANK))
            res = RANK_BITS'(MAX_RANK);
        return res;
    endfunction

    function automatic dim_t dim_fix(input dim_t n);
        dim_t res;
        res = (n == '0) ? DIM_BITS'(1) : n;
        return res;
    endfunction

    function automatic idx_t perm_field(input perm_t perm, input idx_t k);
        perm_t sh;
        sh = perm >> (PERM_FIELD_BITS * k);
        return sh[IDX_BITS-1:0];
    endfunction

    function automatic logic perm_is_bad(input rank_t r, input perm_t perm);
        logic                            bad;
        logic [(2**PERM_FIELD_BITS)-1:0] seen;
        idx_t                            p;
        bad  = 1'b0;
        seen = '0;
        for (int k = 0; k < MAX_RANK; k++)
        begin
            if (RANK_BITS'(k) < r)
            begin
                p = perm[k*PERM_FIELD_BITS +: PERM_FIELD_BITS];
                if (RANK_BITS'(p) >= r || seen[p])
                    bad = 1'b1;
                else
                    seen[p] = 1'b1;
            end
        end
        return bad;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tpag_cell.sv -----
// One odometer digit: rank index, output stride and address step of one
// input dimension. Carry ripples from the inner neighbor. Uses tpag_pkg.
`default_nettype none

module tpag_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tpag_pkg::idx_t   cell_id,
    input  wire tpag_pkg::dim_t   dim_size,
    input  wire logic             in_use,
    input  wire logic             advance,
    input  wire logic             carry_in,
    input  wire tpag_pkg::cell_wr_t wr,
    output logic                  carry_out,
    output logic                  incr,
    output tpag_pkg::addr_t       stride,
    output tpag_pkg::addr_t       step
);

    tpag_pkg::dim_t  idx_reg;
    tpag_pkg::dim_t  idx_next;
    tpag_pkg::addr_t stride_reg;
    tpag_pkg::addr_t stride_next;
    tpag_pkg::addr_t step_reg;
    tpag_pkg::addr_t step_next;
    logic            at_max;
    logic            hit;

    assign at_max    = (idx_reg == dim_size - tpag_pkg::DIM_BITS'(1));
    assign carry_out = carry_in & (at_max | ~in_use);
    assign incr      = carry_in & in_use & ~at_max;
    assign hit       = (wr.sel == cell_id);
    assign stride    = stride_reg;
    assign step      = step_reg;

    always_comb
    begin
        idx_next    = idx_reg;
        stride_next = stride_reg;
        step_next   = step_reg;
        if (wr.clear)
        begin
            idx_next    = '0;
            stride_next = '0;
            step_next   = '0;
        end
        else
        begin
            if (advance && carry_in && in_use)
                idx_next = at_max ? '0 : idx_reg + tpag_pkg::DIM_BITS'(1);
            if (wr.stride_we && hit)
                stride_next = wr.data;
            if (wr.step_we && hit)
                step_next = wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            stride_reg <= '0;
            step_reg   <= '0;
        end
        else
        begin
            idx_reg    <= idx_next;
            stride_reg <= stride_next;
            step_reg   <= step_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tpag_build.sv -----
// Stride builder: walks the ranks with two multipliers and writes the
// strides, then the per-digit address steps, into the cells. Uses tpag_pkg.
`default_nettype none

module tpag_build (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire tpag_pkg::rank_t    rank,
    input  wire tpag_pkg::perm_t    perm_map,
    input  wire logic               perm_bad,
    input  wire tpag_pkg::dim_t     dims    [tpag_pkg::MAX_RANK],
    input  wire tpag_pkg::addr_t    strides [tpag_pkg::MAX_RANK],
    output tpag_pkg::cell_wr_t      wr,
    output logic                    busy
);

    localparam int PROD_BITS = tpag_pkg::ADDR_BITS + tpag_pkg::DIM_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_STRIDE,
        ST_PROD,
        ST_STEP
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    tpag_pkg::idx_t  k_reg;
    tpag_pkg::idx_t  k_next;
    tpag_pkg::addr_t m_reg;
    tpag_pkg::addr_t m_next;
    tpag_pkg::addr_t acc_reg;
    tpag_pkg::addr_t acc_next;
    tpag_pkg::addr_t prod_reg;
    tpag_pkg::addr_t prod_next;

    tpag_pkg::idx_t  p;
    tpag_pkg::idx_t  k_top;
    tpag_pkg::dim_t  dim_p;
    tpag_pkg::dim_t  dim_k;
    tpag_pkg::addr_t stride_k;
    logic [PROD_BITS-1:0] m_full;
    logic [PROD_BITS-1:0] prod_full;

    assign busy  = (state_reg != ST_IDLE);
    assign p     = tpag_pkg::perm_field(perm_map, k_reg);
    assign k_top = tpag_pkg::IDX_BITS'(rank - tpag_pkg::RANK_BITS'(1));

    always_comb
    begin
        dim_p    = tpag_pkg::DIM_BITS'(1);
        dim_k    = tpag_pkg::DIM_BITS'(1);
        stride_k = '0;
        for (int i = 0; i < tpag_pkg::MAX_RANK; i++)
        begin
            if (p == tpag_pkg::IDX_BITS'(i))
                dim_p = dims[i];
            if (k_reg == tpag_pkg::IDX_BITS'(i))
            begin
                dim_k    = dims[i];
                stride_k = strides[i];
            end
        end
    end

    assign m_full    = PROD_BITS'(m_reg) * PROD_BITS'(dim_p);
    assign prod_full = PROD_BITS'(stride_k) * PROD_BITS'(dim_k - tpag_pkg::DIM_BITS'(1));

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        m_next     = m_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        wr         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_CLEAR:
            begin
                wr.clear = 1'b1;
                if (perm_bad)
                    state_next = ST_IDLE;
                else
                begin
                    k_next     = k_top;
                    m_next     = tpag_pkg::ADDR_BITS'(1);
                    state_next = ST_STRIDE;
                end
            end
            ST_STRIDE:
            begin
                wr.stride_we = 1'b1;
                wr.sel       = p;
                wr.data      = m_reg;
                m_next       = m_full[tpag_pkg::ADDR_BITS-1:0];
                if (k_reg == '0)
                begin
                    k_next     = k_top;
                    acc_next   = '0;
                    state_next = ST_PROD;
                end
                else
                    k_next = k_reg - tpag_pkg::IDX_BITS'(1);
            end
            ST_PROD:
            begin
                prod_next  = prod_full[tpag_pkg::ADDR_BITS-1:0];
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                // step = stride minus the rewind of every inner digit
                wr.step_we = 1'b1;
                wr.sel     = k_reg;
                wr.data    = stride_k - acc_reg;
                acc_next   = acc_reg + prod_reg;
                if (k_reg == '0)
                    state_next = ST_IDLE;
                else
                begin
                    k_next     = k_reg - tpag_pkg::IDX_BITS'(1);
                    state_next = ST_PROD;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        if (start)
            state_next = ST_CLEAR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            k_reg     <= '0;
            m_reg     <= '0;
            acc_reg   <= '0;
            prod_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            m_reg     <= m_next;
            acc_reg   <= acc_next;
            prod_reg  <= prod_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tensor_permute_address_generator_top.sv -----
// Results are registered: an accepted item shows at the outputs in the next cycle.
// Throughput: one item per cycle when elem_stall is low; odometer carry is combinational.
// After reset and after each register write the stride builder clears the cells and, unless
// the permutation is bad, writes strides then steps, one multiply per cycle, input stalled.
// Reset: asynchronous, active low; registers return to rank 1, sizes 1, perm_map 0.
`default_nettype none

module tensor_permute_address_generator_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 elem_valid,
    output logic                                      elem_stall,
    input  wire logic [tpag_pkg::VALUE_BITS-1:0]      elem_value,
    output logic                                      result_valid,
    input  wire logic                                 result_stall,
    output logic [tpag_pkg::VALUE_BITS-1:0]           result_value,
    output logic [tpag_pkg::ADDR_BITS-1:0]            out_address,
    output logic                                      last_element,
    output logic                                      config_error,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [tpag_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [tpag_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    tpag_pkg::rank_t    rank_count_reg;
    tpag_pkg::dim_t     dim_size_reg [tpag_pkg::MAX_RANK];
    tpag_pkg::perm_t    perm_map_reg;

    tpag_pkg::rank_t    rank;
    tpag_pkg::dim_t     dims    [tpag_pkg::MAX_RANK];
    tpag_pkg::addr_t    strides [tpag_pkg::MAX_RANK];
    tpag_pkg::addr_t    steps   [tpag_pkg::MAX_RANK];
    logic [tpag_pkg::MAX_RANK-1:0] incr;
    logic [tpag_pkg::MAX_RANK:0]   carry;
    logic               perm_bad;
    logic               cfg_we;
    logic               build_start;
    logic               busy;
    logic               accept;
    logic               last;
    tpag_pkg::cell_wr_t wr;
    tpag_pkg::addr_t    step_sel;

    tpag_pkg::addr_t    addr_reg;
    tpag_pkg::addr_t    addr_next;
    logic               result_valid_reg;
    logic [tpag_pkg::VALUE_BITS-1:0] result_value_reg;
    tpag_pkg::addr_t    out_address_reg;
    logic               last_element_reg;
    logic               config_error_reg;

    assign cfg_ready   = 1'b1;
    assign cfg_we      = cfg_valid & cfg_ready;
    assign build_start = cfg_we && (cfg_index <= tpag_pkg::REG_PERM_MAP);

    assign rank     = tpag_pkg::ranks_used(rank_count_reg);
    assign perm_bad = tpag_pkg::perm_is_bad(rank, perm_map_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_count_reg <= tpag_pkg::RANK_BITS'(1);
            perm_map_reg   <= '0;
            for (int d = 0; d < tpag_pkg::MAX_RANK; d++)
                dim_size_reg[d] <= tpag_pkg::DIM_BITS'(1);
        end
        else if (cfg_we)
        begin
            priority if (cfg_index == tpag_pkg::REG_RANK_COUNT)
                rank_count_reg <= cfg_data[tpag_pkg::RANK_BITS-1:0];
            else if (cfg_index == tpag_pkg::REG_PERM_MAP)
                perm_map_reg <= cfg_data[tpag_pkg::PERM_BITS-1:0];
            else
            begin
                for (int d = 0; d < tpag_pkg::MAX_RANK; d++)
                    if (cfg_index == tpag_pkg::REG_DIM_SIZE_0 + tpag_pkg::CFG_INDEX_BITS'(d))
                        dim_size_reg[d] <= cfg_data[tpag_pkg::DIM_BITS-1:0];
            end
        end
    end

    tpag_build u_build (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (build_start),
        .rank     (rank),
        .perm_map (perm_map_reg),
        .perm_bad (perm_bad),
        .dims     (dims),
        .strides  (strides),
        .wr       (wr),
        .busy     (busy)
    );

    assign elem_stall = busy | (result_valid_reg & result_stall);
    assign accept     = elem_valid & ~elem_stall;

    // innermost used digit takes the incoming carry
    assign carry[tpag_pkg::MAX_RANK] = 1'b1;

    for (genvar d = 0; d < tpag_pkg::MAX_RANK; d++)
    begin : g_cell
        assign dims[d] = tpag_pkg::dim_fix(dim_size_reg[d]);

        tpag_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_id   (tpag_pkg::IDX_BITS'(d)),
            .dim_size  (dims[d]),
            .in_use    (tpag_pkg::RANK_BITS'(d) < rank),
            .advance   (accept),
            .carry_in  (carry[d+1]),
            .wr        (wr),
            .carry_out (carry[d]),
            .incr      (incr[d]),
            .stride    (strides[d]),
            .step      (steps[d])
        );
    end

    assign last = carry[0];

    always_comb
    begin
        step_sel = '0;
        for (int d = 0; d < tpag_pkg::MAX_RANK; d++)
            if (incr[d])
                step_sel = step_sel | steps[d];
    end

    always_comb
    begin
        addr_next = addr_reg;
        if (wr.clear)
            addr_next = '0;
        else if (accept)
            addr_next = last ? '0 : addr_reg + step_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            addr_reg <= addr_next;
            if (accept)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_value_reg <= elem_value;
            out_address_reg  <= perm_bad ? '0 : addr_reg;
            last_element_reg <= last;
            config_error_reg <= perm_bad;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_value = result_value_reg;
    assign out_address  = out_address_reg;
    assign last_element = last_element_reg;
    assign config_error = config_error_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tpag_checker.sv -----
// Port-level checks for tensor_permute_address_generator_top, bound to it below.
// Uses tpag_pkg and tensor_permute_address_generator_top_macros.svh.
`default_nettype none
`include "tensor_permute_address_generator_top_macros.svh"

module tpag_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                elem_stall,
    input wire logic                                result_valid,
    input wire logic                                result_stall,
    input wire logic [tpag_pkg::VALUE_BITS-1:0]     result_value,
    input wire logic [tpag_pkg::ADDR_BITS-1:0]      out_address,
    input wire logic                                last_element,
    input wire logic                                config_error,
    input wire logic                                cfg_valid,
    input wire logic                                cfg_ready,
    input wire logic [tpag_pkg::CFG_INDEX_BITS-1:0] cfg_index
);

    `TPAG_ASSERT_NOW(a_err_addr_zero, result_valid && config_error, out_address == '0, "bad permutation item carries nonzero address")

    `TPAG_ASSERT_NEXT(a_cfg_rebuild_stalls, cfg_valid && cfg_ready && (cfg_index <= tpag_pkg::REG_PERM_MAP), elem_stall, "input not stalled during stride rebuild")

    `TPAG_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result_value) && $stable(out_address) && $stable(last_element), "stalled item changed")

endmodule

bind tensor_permute_address_generator_top tpag_checker u_tpag_checker (.*);

`default_nettype wire
